FILE: design/rcbm_pkg.sv
`default_nettype none
package rcbm_pkg;

  localparam int unsigned PointsDefault = 8;
  localparam int unsigned QueueDepth    = 2;
  localparam logic [15:0] SpeedMax      = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_SET   = 2'd1,
    OP_EVAL  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_OFF,
    KIND_FLAT,
    KIND_INTERP
  } kind_e;

  typedef enum logic [3:0] {
    F_IDLE,
    F_DN_RD,
    F_DN_CMP,
    F_UP_RD,
    F_UP_CMP,
    F_LO_RD,
    F_LO_CAP,
    F_HI_RD,
    F_HI_CAP,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_SUM,
    B_DIV
  } back_state_e;

  // duty[0] red, duty[1] green, duty[2] blue
  typedef struct packed {
    logic [2:0][7:0] duty;
    logic [15:0]     spd;
  } entry_t;

  typedef struct packed {
    op_e         op;
    logic [3:0]  entry_index;
    logic [15:0] entry_speed;
    logic [7:0]  entry_red;
    logic [7:0]  entry_green;
    logic [7:0]  entry_blue;
    logic [15:0] speed;
    logic        reselect;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    entry_t      lo;
    entry_t      hi;
    logic [15:0] spd;
    logic [3:0]  seg;
  } job_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [3:0] seg;
  } result_t;

endpackage
`default_nettype wire

FILE: design/rcbm_ram.sv
`default_nettype none
module rcbm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

FILE: design/rcbm_front.sv
`default_nettype none
module rcbm_front #(
  parameter int unsigned POINTS = rcbm_pkg::PointsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               item_valid_i,
  output logic                    item_ready_o,
  input  wire rcbm_pkg::in_item_t item_i,
  input  wire logic [15:0]        hyst_i,
  input  wire logic               full_i,
  output logic                    push_o,
  output rcbm_pkg::job_t          job_o
);
  import rcbm_pkg::*;

  localparam int unsigned IW = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int unsigned SW = $clog2(POINTS + 1);
  localparam logic [SW-1:0] SegOff  = SW'(POINTS);
  localparam logic [SW-1:0] SegLast = SW'(POINTS - 1);

  front_state_e state_q, state_d;
  logic [SW-1:0] seg_q;
  logic [POINTS-1:0] valid_q;
  logic rvalid_q;
  logic [15:0] spd_q;
  logic resel_q;
  entry_t lo_q, hi_q;

  logic we;
  logic [IW-1:0] waddr, raddr;
  logic [39:0] rdata;
  entry_t wentry, rentry;
  logic accept;
  logic [16:0] lo_sum, hi_sum;
  logic [15:0] lo_bound, hi_bound;
  logic dn_step, up_step;

  assign accept = item_valid_i && item_ready_o;
  assign we     = accept && (item_i.op == OP_WRITE) && ({1'b0, item_i.entry_index} < 5'(POINTS));
  assign waddr  = IW'(item_i.entry_index);
  assign wentry = '{duty: {item_i.entry_blue, item_i.entry_green, item_i.entry_red},
                    spd: item_i.entry_speed};

  rcbm_ram #(.WIDTH(40), .DEPTH(POINTS)) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wentry),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // entries never written read as zero
  assign rentry = rvalid_q ? entry_t'(rdata) : '0;

  assign lo_sum   = {1'b0, rentry.spd} - {1'b0, hyst_i};
  assign lo_bound = (rentry.spd > hyst_i) ? lo_sum[15:0] : 16'd0;
  assign hi_sum   = {1'b0, rentry.spd} + {1'b0, hyst_i};
  assign hi_bound = hi_sum[16] ? SpeedMax : hi_sum[15:0];
  assign dn_step  = resel_q && (seg_q != '0) && (spd_q < lo_bound);
  assign up_step  = resel_q && (seg_q < SegLast) && (spd_q > hi_bound);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      seg_q    <= '0;
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= valid_q[raddr];
      if (we) begin
        valid_q[waddr] <= 1'b1;
      end
      if (accept && item_i.op == OP_SET) begin
        seg_q <= ({1'b0, item_i.entry_index} > 5'(POINTS)) ? SegOff : SW'(item_i.entry_index);
      end
      if (state_q == F_DN_CMP && dn_step) begin
        seg_q <= seg_q - 1'b1;
      end
      if (state_q == F_UP_CMP && up_step) begin
        seg_q <= seg_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      spd_q   <= item_i.speed;
      resel_q <= item_i.reselect;
    end
    if (state_q == F_LO_CAP) begin
      lo_q <= rentry;
    end
    if (state_q == F_HI_CAP) begin
      hi_q <= (seg_q < SegOff) ? rentry : '0;
    end
  end

  always_comb begin
    state_d      = state_q;
    item_ready_o = 1'b0;
    push_o       = 1'b0;
    raddr        = '0;
    unique case (state_q)
      F_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i && item_i.op == OP_EVAL) begin
          state_d = F_DN_RD;
        end
      end
      F_DN_RD: begin
        raddr   = (seg_q != '0) ? IW'(seg_q - 1'b1) : '0;
        state_d = F_DN_CMP;
      end
      F_DN_CMP: state_d = F_UP_RD;
      F_UP_RD: begin
        raddr   = (seg_q < SegOff) ? IW'(seg_q) : IW'(SegLast);
        state_d = F_UP_CMP;
      end
      F_UP_CMP: state_d = F_LO_RD;
      F_LO_RD: begin
        raddr   = (seg_q != '0) ? IW'(seg_q - 1'b1) : '0;
        state_d = F_LO_CAP;
      end
      F_LO_CAP: state_d = F_HI_RD;
      F_HI_RD: begin
        raddr   = (seg_q < SegOff) ? IW'(seg_q) : IW'(SegLast);
        state_d = F_HI_CAP;
      end
      F_HI_CAP: state_d = F_PUSH;
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    job_o.lo  = lo_q;
    job_o.hi  = hi_q;
    job_o.spd = spd_q;
    job_o.seg = 4'(seg_q);
    if (seg_q >= SegOff) begin
      job_o.kind = KIND_OFF;
    end else if (seg_q == '0 || seg_q == SegLast) begin
      job_o.kind = KIND_FLAT;
    end else begin
      job_o.kind = KIND_INTERP;
    end
  end

endmodule
`default_nettype wire

FILE: design/rcbm_queue.sv
`default_nettype none
module rcbm_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire rcbm_pkg::job_t job_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output rcbm_pkg::job_t      job_o
);
  import rcbm_pkg::*;

  localparam int unsigned PW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CW = $clog2(QueueDepth + 1);

  job_t slot_q [QueueDepth];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= job_i;
    end
  end

endmodule
`default_nettype wire

FILE: design/rcbm_back.sv
`default_nettype none
module rcbm_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           job_valid_i,
  input  wire rcbm_pkg::job_t job_i,
  output logic                pop_o,
  output logic                res_valid_o,
  input  wire logic           res_ready_i,
  output rcbm_pkg::result_t   res_o
);
  import rcbm_pkg::*;

  back_state_e state_q;
  job_t job_q;
  logic [1:0] ch_q;
  logic [2:0] bit_q;
  logic signed [25:0] p1_q, p2_q;
  logic signed [16:0] ds_q;
  logic [15:0] den_q;
  logic [23:0] rem_q;
  logic [7:0] quo_q;
  logic [2:0][7:0] duty_q;
  logic out_valid_q;

  logic [7:0] hd, ld;
  logic signed [16:0] ds, sd;
  logic signed [8:0] dd;
  logic signed [26:0] num, num_n;
  logic signed [16:0] den_n;
  logic [23:0] shifted, rem_next;
  logic take;

  assign hd = job_q.hi.duty[ch_q];
  assign ld = job_q.lo.duty[ch_q];
  assign ds = $signed({1'b0, job_q.hi.spd}) - $signed({1'b0, job_q.lo.spd});
  assign sd = $signed({1'b0, job_q.spd}) - $signed({1'b0, job_q.hi.spd});
  assign dd = $signed({1'b0, hd}) - $signed({1'b0, ld});

  assign num   = 27'(p1_q) + 27'(p2_q);
  assign num_n = ds_q[16] ? -num : num;
  assign den_n = ds_q[16] ? -ds_q : ds_q;

  assign shifted  = {8'd0, den_q} << bit_q;
  assign take     = rem_q >= shifted;
  assign rem_next = take ? rem_q - shifted : rem_q;

  assign pop_o       = (state_q == B_IDLE) && job_valid_i && !out_valid_q;
  assign res_valid_o = out_valid_q;
  assign res_o = '{red: duty_q[0], green: duty_q[1], blue: duty_q[2], seg: job_q.seg};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      ch_q        <= '0;
      bit_q       <= '0;
    end else begin
      if (out_valid_q && res_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (pop_o) begin
            ch_q <= '0;
            unique case (job_i.kind)
              KIND_INTERP: state_q <= B_MUL;
              default: out_valid_q <= 1'b1;
            endcase
          end
        end
        B_MUL: state_q <= B_SUM;
        B_SUM: begin
          if (ds_q == '0 || num_n <= 27'sd0 || num_n >= $signed({3'b0, den_n[15:0], 8'd0})) begin
            if (ch_q == 2'd2) begin
              state_q     <= B_IDLE;
              out_valid_q <= 1'b1;
            end else begin
              ch_q    <= ch_q + 1'b1;
              state_q <= B_MUL;
            end
          end else begin
            bit_q   <= 3'd7;
            state_q <= B_DIV;
          end
        end
        B_DIV: begin
          bit_q <= bit_q - 1'b1;
          if (bit_q == '0) begin
            if (ch_q == 2'd2) begin
              state_q     <= B_IDLE;
              out_valid_q <= 1'b1;
            end else begin
              ch_q    <= ch_q + 1'b1;
              state_q <= B_MUL;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
      unique case (job_i.kind)
        KIND_OFF:  duty_q <= '0;
        KIND_FLAT: duty_q <= job_i.hi.duty;
        default:   duty_q <= duty_q;
      endcase
    end
    if (state_q == B_MUL) begin
      p1_q <= $signed({1'b0, hd}) * ds;
      p2_q <= sd * dd;
      ds_q <= ds;
    end
    if (state_q == B_SUM) begin
      den_q <= den_n[15:0];
      rem_q <= num_n[23:0];
      quo_q <= '0;
      if (ds_q == '0) begin
        duty_q[ch_q] <= hd;
      end else if (num_n <= 27'sd0) begin
        duty_q[ch_q] <= 8'd0;
      end else if (num_n >= $signed({3'b0, den_n[15:0], 8'd0})) begin
        duty_q[ch_q] <= 8'hFF;
      end
    end
    if (state_q == B_DIV) begin
      rem_q        <= rem_next;
      quo_q[bit_q] <= take;
      if (bit_q == '0) begin
        duty_q[ch_q] <= {quo_q[7:1], take};
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/rpm_color_breakpoint_mapper.sv
// evaluate: the front reads the step-down, step-up, low and high table entries, then pushes a job;
// interpolation runs three channels, each with an 8-step restoring divide unless the duty clamps
// flow: write and set items are taken while the front is idle; evaluate items hold the front
// table-read sequencer until the job is pushed, and the back divider sets the sustained rate
// reset: asynchronous active low; table reads as zero, segment 0, hysteresis 0
`default_nettype none
module rpm_color_breakpoint_mapper #(
  parameter int unsigned POINTS = rcbm_pkg::PointsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,   // hysteresis
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // entry_index[3:0] entry_speed[19:4] entry_red[27:20] entry_green[35:28]
  // entry_blue[43:36] speed[59:44] reselect[60]
  input  wire logic [63:0] s_axis_tdata,
  input  wire logic [1:0]  s_axis_tuser, // op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // red_duty[7:0] green_duty[15:8] blue_duty[23:16] segment[27:24]
  output logic [31:0]      m_axis_tdata
);
  import rcbm_pkg::*;

  logic [15:0] hyst_q;
  in_item_t item;
  job_t fjob, qjob;
  logic push, full, pop, empty;
  result_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hyst_q <= '0;
    end else if (cfg_valid_i) begin
      hyst_q <= cfg_data_i;
    end
  end

  assign item = '{op: op_e'(s_axis_tuser), entry_index: s_axis_tdata[3:0],
                  entry_speed: s_axis_tdata[19:4], entry_red: s_axis_tdata[27:20],
                  entry_green: s_axis_tdata[35:28], entry_blue: s_axis_tdata[43:36],
                  speed: s_axis_tdata[59:44], reselect: s_axis_tdata[60]};

  rcbm_front #(.POINTS(POINTS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(s_axis_tvalid),
    .item_ready_o(s_axis_tready),
    .item_i      (item),
    .hyst_i      (hyst_q),
    .full_i      (full),
    .push_o      (push),
    .job_o       (fjob)
  );

  rcbm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (fjob),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .job_o  (qjob)
  );

  rcbm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(!empty),
    .job_i      (qjob),
    .pop_o      (pop),
    .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tdata = {4'd0, res.seg, res.blue, res.green, res.red};

endmodule
`default_nettype wire

FILE: design/rcbm_checker.sv
`default_nettype none
module rcbm_checker #(
  parameter int unsigned POINTS = rcbm_pkg::PointsDefault
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);
  import rcbm_pkg::*;

  localparam logic [4:0] SegOff = 5'(POINTS);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && POINTS < 16 |-> {1'b0, m_axis_tdata[27:24]} <= SegOff)
    else $error("segment beyond off");

  a_off_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && POINTS < 16 && {1'b0, m_axis_tdata[27:24]} == SegOff
    |-> m_axis_tdata[23:0] == 24'd0)
    else $error("lights off with nonzero duty");

  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_EVAL |=> !s_axis_tready)
    else $error("evaluate did not occupy front");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write refused");

endmodule

bind rpm_color_breakpoint_mapper rcbm_checker #(.POINTS(POINTS)) u_rcbm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_valid_i  (cfg_valid_i),
  .cfg_ready_o  (cfg_ready_o),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
`default_nettype wire
